// File: rtl/core/rpfa_pkg.sv
// ----------------------------------------------------------------------------
// rpfa_pkg
// Shared types, codes and widths of the reference-counted page frame allocator.
// ----------------------------------------------------------------------------
package rpfa_pkg;

  // Fixed field widths of the stream items.
  localparam int PAGE_W      = 15;
  localparam int MODE_W      = 3;
  localparam int CNT_OUT_W   = 8;
  localparam int STAT_W      = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Default configuration of the top level.
  localparam int NPAGES_DEF      = 32768;
  localparam int COUNT_WIDTH_DEF = 8;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INC   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEC   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOMEM = 3'd2;
  localparam logic [STAT_W-1:0] STAT_UNDER = 3'd3;
  localparam logic [STAT_W-1:0] STAT_OVER  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write one zero count during the clearing sweep
    logic start;   // latch the item and issue the memory reads
    logic commit;  // write memories and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the sweep is at its last entry
    logic out_free;    // the result register can take a new item
  } stat_t;

endpackage

// File: rtl/core/rpfa_ram.sv
// ----------------------------------------------------------------------------
// rpfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/rpfa_ctrl.sv
// ----------------------------------------------------------------------------
// rpfa_ctrl
// Controller: clearing sweep after reset, then a read and a commit per item.
// ----------------------------------------------------------------------------
module rpfa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rpfa_pkg::stat_t    stat_i,
  output rpfa_pkg::cmd_t     cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.clear  = 1'b0;
    cmd_o.start  = 1'b0;
    cmd_o.commit = 1'b0;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // Hold the item until the result register is free.
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/rpfa_dp.sv
// ----------------------------------------------------------------------------
// rpfa_dp
// Datapath: count and stack memories, stack pointers and result register.
// ----------------------------------------------------------------------------
module rpfa_dp #(
  parameter int NPAGES      = rpfa_pkg::NPAGES_DEF,
  parameter int COUNT_WIDTH = rpfa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rpfa_pkg::cmd_t                      cmd_i,
  output rpfa_pkg::stat_t                     stat_o,
  input  logic                                cfg_we_i,
  input  logic [rpfa_pkg::PAGE_W-1:0]         cfg_wdata_i,
  input  logic [rpfa_pkg::MODE_W-1:0]         in_mode_i,
  input  logic [rpfa_pkg::PAGE_W-1:0]         in_page_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rpfa_pkg::OUT_TDATA_W-1:0]    out_data_o
);

  localparam int PW = $clog2(NPAGES);
  localparam int DW = PW + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
  localparam int PAD_W = rpfa_pkg::OUT_TDATA_W - rpfa_pkg::PAGE_W - rpfa_pkg::CNT_OUT_W
                         - 1 - rpfa_pkg::STAT_W;

  // Configuration and stack pointers.
  logic [rpfa_pkg::PAGE_W-1:0] first_page_q;
  logic [DW-1:0]               stack_depth_q, stack_depth_d;
  logic [DW-1:0]               fresh_next_q, fresh_next_d;
  logic [PW-1:0]               clr_addr_q;

  // Latched item.
  logic [rpfa_pkg::MODE_W-1:0] mode_q;
  logic [rpfa_pkg::PAGE_W-1:0] page_q;

  // Memory ports.
  logic                   cnt_we;
  logic [PW-1:0]          cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic [COUNT_WIDTH-1:0] cnt_rdata;
  logic                   stk_we;
  logic [PW-1:0]          stk_rdata;

  // Result register.
  logic                            out_valid_q;
  logic [rpfa_pkg::OUT_TDATA_W-1:0] out_data_q;

  // Operation results.
  logic                            in_range;
  logic                            stack_nonempty;
  logic                            fresh_avail;
  logic [PW-1:0]                   got;
  logic [PW-1:0]                   page_w;
  logic                            op_cnt_we;
  logic [PW-1:0]                   op_cnt_addr;
  logic [COUNT_WIDTH-1:0]          op_cnt_data;
  logic                            push;
  logic [rpfa_pkg::PAGE_W-1:0]     res_page;
  logic [COUNT_WIDTH-1:0]          res_cnt;
  logic                            res_back;
  logic [rpfa_pkg::STAT_W-1:0]     res_stat;

  rpfa_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NPAGES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cmd_i.start),
    .raddr_i (PW'(in_page_i)),
    .rdata_o (cnt_rdata)
  );

  rpfa_ram #(
    .WIDTH (PW),
    .DEPTH (NPAGES)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (PW'(stack_depth_q)),
    .wdata_i (page_w),
    .re_i    (cmd_i.start),
    .raddr_i (PW'(stack_depth_q - DW'(1))),
    .rdata_o (stk_rdata)
  );

  assign page_w         = PW'(page_q);
  assign in_range       = (32'(page_q) >= 32'(first_page_q)) && (32'(page_q) < 32'(NPAGES));
  assign stack_nonempty = (stack_depth_q != '0);
  assign fresh_avail    = (32'(fresh_next_q) > 32'(first_page_q));
  assign got            = stack_nonempty ? stk_rdata : PW'(fresh_next_q - DW'(1));

  always_comb begin
    stack_depth_d = stack_depth_q;
    fresh_next_d  = fresh_next_q;
    op_cnt_we     = 1'b0;
    op_cnt_addr   = page_w;
    op_cnt_data   = cnt_rdata;
    push          = 1'b0;
    res_page      = page_q;
    res_cnt       = cnt_rdata;
    res_back      = 1'b0;
    res_stat      = rpfa_pkg::STAT_OK;
    if (mode_q == rpfa_pkg::MODE_ALLOC) begin
      // Explicit stack first, then the fresh region below it.
      if (stack_nonempty || fresh_avail) begin
        if (stack_nonempty) begin
          stack_depth_d = stack_depth_q - DW'(1);
        end else begin
          fresh_next_d = fresh_next_q - DW'(1);
        end
        op_cnt_we   = 1'b1;
        op_cnt_addr = got;
        op_cnt_data = CNT_ONE;
        res_page    = rpfa_pkg::PAGE_W'(got);
        res_cnt     = CNT_ONE;
      end else begin
        res_page = '0;
        res_cnt  = '0;
        res_stat = rpfa_pkg::STAT_NOMEM;
      end
    end else if (!in_range) begin
      res_cnt  = '0;
      res_stat = rpfa_pkg::STAT_RANGE;
    end else begin
      case (mode_q)
        rpfa_pkg::MODE_FREE, rpfa_pkg::MODE_DEC: begin
          if (cnt_rdata == '0) begin
            res_stat = rpfa_pkg::STAT_UNDER;
          end else begin
            op_cnt_we   = 1'b1;
            op_cnt_data = cnt_rdata - CNT_ONE;
            res_cnt     = cnt_rdata - CNT_ONE;
            // A free that drops the last reference returns the frame, unless
            // the stack is already full.
            if ((mode_q == rpfa_pkg::MODE_FREE) && (cnt_rdata == CNT_ONE) &&
                (32'(stack_depth_q) < 32'(NPAGES))) begin
              push          = 1'b1;
              stack_depth_d = stack_depth_q + DW'(1);
              res_back      = 1'b1;
            end
          end
        end
        rpfa_pkg::MODE_INC: begin
          if (cnt_rdata == CNT_MAX) begin
            res_stat = rpfa_pkg::STAT_OVER;
          end else begin
            op_cnt_we   = 1'b1;
            op_cnt_data = cnt_rdata + CNT_ONE;
            res_cnt     = cnt_rdata + CNT_ONE;
          end
        end
        default: begin
          // Read count, also for the unused codes.
        end
      endcase
    end
  end

  // The clearing sweep owns the count memory until it ends.
  assign cnt_we    = cmd_i.clear || (cmd_i.commit && op_cnt_we);
  assign cnt_waddr = cmd_i.clear ? clr_addr_q : op_cnt_addr;
  assign cnt_wdata = cmd_i.clear ? '0 : op_cnt_data;
  assign stk_we    = cmd_i.commit && push;

  assign stat_o.clear_last = (clr_addr_q == PW'(NPAGES - 1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_page_q  <= '0;
      stack_depth_q <= '0;
      fresh_next_q  <= DW'(NPAGES);
      clr_addr_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        first_page_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + PW'(1);
      end
      if (cmd_i.commit) begin
        stack_depth_q <= stack_depth_d;
        fresh_next_q  <= fresh_next_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q <= in_mode_i;
      page_q <= in_page_i;
    end
    if (cmd_i.commit) begin
      out_data_q <= {{PAD_W{1'b0}}, res_stat, res_back,
                     rpfa_pkg::CNT_OUT_W'(res_cnt), res_page};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/core/refcounted_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator
// Page frame allocator with a LIFO free stack and a reference count per frame.
// ----------------------------------------------------------------------------
// Flow: an accepted item's result is registered in the commit state that
// follows; that state waits only while the previous result waits downstream.
// A new item is taken only once the previous one is committed, due to the
// read-then-write of the count and stack memories through their single
// registered read ports. Reset: asynchronous, active low. After reset a
// clearing sweep writes zero to every count, during which no item is
// accepted; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator #(
  parameter int NPAGES      = rpfa_pkg::NPAGES_DEF,
  parameter int COUNT_WIDTH = rpfa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration: first usable page frame.
  input  logic                               cfg_we_i,
  input  logic [rpfa_pkg::PAGE_W-1:0]        cfg_wdata_i,
  // Request stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // From bit 0: mode[2:0], page_index[17:3], zero fill [23:18].
  input  logic [rpfa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // From bit 0: result_page[14:0], ref_count[22:15], returned_to_pool[23],
  // status[26:24], zero fill [31:27].
  output logic [rpfa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  // The controller sequences each item as a read step followed by a commit
  // step; the datapath holds the memories, the stack depth, the fresh-frame
  // pointer and the result register. The result register lets the controller
  // take the next item while a finished result still waits downstream.
  rpfa_pkg::cmd_t  cmd;
  rpfa_pkg::stat_t stat;

  rpfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rpfa_dp #(
    .NPAGES      (NPAGES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_mode_i   (s_axis_tdata[rpfa_pkg::MODE_W-1:0]),
    .in_page_i   (s_axis_tdata[rpfa_pkg::MODE_W +: rpfa_pkg::PAGE_W]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: sim/refcounted_page_frame_allocator_tb.sv
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_tb
// Self-checking testbench of the reference-counted page frame allocator.
// ----------------------------------------------------------------------------
// A driver feeds requests from a queue onto the request stream. A monitor
// keeps its own copy of the free stack, the fresh-frame pointer and the
// reference counts. It predicts the reply to each accepted request and
// compares every returned reply, field by field, with the oldest prediction.
// The first part is directed: both ends of the page range, every operation,
// the unused mode codes, underflow, overflow and running out of frames. Then
// random requests are sent under several first-page settings. Both stream
// sides insert random waits, except in stretches where the traffic runs
// back to back.
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator_tb;

  localparam int NPAGES     = rpfa_pkg::NPAGES_DEF;
  localparam int CNT_MAX    = (1 << rpfa_pkg::COUNT_WIDTH_DEF) - 1;
  localparam int WDOG_LIMIT = 4 * NPAGES;  // outlasts the clearing sweep of NPAGES counts

  // Bit positions of the reply fields in m_axis_tdata.
  localparam int CNT_LSB  = rpfa_pkg::PAGE_W;
  localparam int BACK_BIT = rpfa_pkg::PAGE_W + rpfa_pkg::CNT_OUT_W;
  localparam int STAT_LSB = BACK_BIT + 1;

  // Mode codes without an operation of their own; the block treats them as a read.
  localparam logic [rpfa_pkg::MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [rpfa_pkg::MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [rpfa_pkg::MODE_W-1:0] MODE_RSVD7 = 3'd7;

  // Allocations come from the top of the range, so most random requests aim there.
  localparam logic [rpfa_pkg::PAGE_W-1:0] TOP_WINDOW_LO = 15'd32704;
  localparam logic [rpfa_pkg::PAGE_W-1:0] OVF_PAGE      = 15'd16000;

  typedef struct {
    logic                        hold;  // wait until every earlier reply is back
    logic [rpfa_pkg::MODE_W-1:0] mode;
    logic [rpfa_pkg::PAGE_W-1:0] page;
  } page_req_t;

  typedef struct {
    logic [rpfa_pkg::PAGE_W-1:0]    page;
    logic [rpfa_pkg::CNT_OUT_W-1:0] cnt;
    logic                           back;
    logic [rpfa_pkg::STAT_W-1:0]    status;
  } page_reply_t;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             cfg_we_i      = 1'b0;
  logic [rpfa_pkg::PAGE_W-1:0]      cfg_wdata_i   = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [rpfa_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [rpfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  // Requests waiting to be sent and replies predicted but not yet returned.
  page_req_t   req_q[$];
  page_reply_t predicted_replies_q[$];

  // Shadow state of the allocator, owned by the monitor.
  logic [rpfa_pkg::CNT_OUT_W-1:0] cnt_mem[NPAGES];
  logic [rpfa_pkg::PAGE_W-1:0]    stk_mem[NPAGES];
  int unsigned                    stk_depth;
  int unsigned                    fresh_ptr;
  logic [rpfa_pkg::PAGE_W-1:0]    first_pg;

  int unsigned                 sent_total;   // items accepted on the request side (driver)
  int unsigned                 done_total;   // items accepted on the reply side (monitor)
  int unsigned                 tx_wait;
  int unsigned                 rx_wait;
  int unsigned                 fail_cnt = 0;
  int unsigned                 wdog_cnt = 0;
  logic                        idle_on  = 1'b1;  // random waits on both sides when set
  logic [rpfa_pkg::PAGE_W-1:0] gen_first = '0;   // first page as the stimulus sees it

  refcounted_page_frame_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    return idle_on ? $urandom_range(0, 15) : 0;
  endfunction

  // Applies one request to the shadow state and returns the reply it causes.
  function automatic page_reply_t apply_page_op(input logic [rpfa_pkg::MODE_W-1:0] op,
                                                input logic [rpfa_pkg::PAGE_W-1:0] pg);
    page_reply_t r;
    logic [rpfa_pkg::CNT_OUT_W-1:0] c;
    r.page   = pg;
    r.cnt    = '0;
    r.back   = 1'b0;
    r.status = rpfa_pkg::STAT_OK;
    if (op == rpfa_pkg::MODE_ALLOC) begin
      // The explicit stack is always drained before the fresh region.
      r.page = '0;
      if (stk_depth > 0) begin
        stk_depth--;
        r.page = stk_mem[stk_depth];
      end else if (fresh_ptr > first_pg) begin
        fresh_ptr--;
        r.page = fresh_ptr[rpfa_pkg::PAGE_W-1:0];
      end else begin
        r.status = rpfa_pkg::STAT_NOMEM;
        return r;
      end
      cnt_mem[r.page] = rpfa_pkg::CNT_OUT_W'(1);
      r.cnt = rpfa_pkg::CNT_OUT_W'(1);
      return r;
    end
    if (pg < first_pg) begin
      r.status = rpfa_pkg::STAT_RANGE;
      return r;
    end
    c = cnt_mem[pg];
    case (op)
      rpfa_pkg::MODE_FREE, rpfa_pkg::MODE_DEC: begin
        if (c == 0) begin
          r.status = rpfa_pkg::STAT_UNDER;
        end else begin
          c--;
          cnt_mem[pg] = c;
          // A full stack silently drops the push.
          if (op == rpfa_pkg::MODE_FREE && c == 0 && stk_depth < NPAGES) begin
            stk_mem[stk_depth] = pg;
            stk_depth++;
            r.back = 1'b1;
          end
        end
      end
      rpfa_pkg::MODE_INC: begin
        if (c == CNT_MAX) begin
          r.status = rpfa_pkg::STAT_OVER;
        end else begin
          c++;
          cnt_mem[pg] = c;
        end
      end
      default: ;
    endcase
    r.cnt = c;
    return r;
  endfunction

  function automatic bit field_ok(input string name, input int unsigned exp_v,
                                  input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Driver: presents the next request once the previous one is taken and the
  // drawn wait has run out. A held request waits until all replies are back.
  always @(posedge clk_i or negedge rst_ni) begin
    page_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      tx_wait    = 0;
      sent_total = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) sent_total++;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() != 0 && !(req_q[0].hold && sent_total != done_total)) begin
          nxt = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(rpfa_pkg::IN_TDATA_W - rpfa_pkg::PAGE_W - rpfa_pkg::MODE_W){1'b0}},
                            nxt.page, nxt.mode};
          tx_wait = draw_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: tracks configuration writes, predicts a reply for each accepted
  // request, checks each returned reply and stalls the reply side at random.
  always @(posedge clk_i or negedge rst_ni) begin
    page_reply_t exp_r;
    page_reply_t got_r;
    bit ok;
    if (!rst_ni) begin
      for (int i = 0; i < NPAGES; i++) begin
        cnt_mem[i] = '0;
        stk_mem[i] = '0;
      end
      stk_depth = 0;
      fresh_ptr = NPAGES;
      first_pg  = '0;
      predicted_replies_q.delete();
      rx_wait = 0;
      done_total    <= 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (cfg_we_i) first_pg = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        done_total <= done_total + 1;
        got_r.page   = m_axis_tdata[rpfa_pkg::PAGE_W-1:0];
        got_r.cnt    = m_axis_tdata[CNT_LSB +: rpfa_pkg::CNT_OUT_W];
        got_r.back   = m_axis_tdata[BACK_BIT];
        got_r.status = m_axis_tdata[STAT_LSB +: rpfa_pkg::STAT_W];
        if (predicted_replies_q.size() == 0) begin
          $error("reply with no request pending: page %0d status %0d",
                 got_r.page, got_r.status);
          fail_cnt++;
        end else begin
          exp_r = predicted_replies_q.pop_front();
          ok = field_ok("result_page", 32'(exp_r.page), 32'(got_r.page));
          ok = field_ok("ref_count", 32'(exp_r.cnt), 32'(got_r.cnt)) && ok;
          ok = field_ok("returned_to_pool", 32'(exp_r.back), 32'(got_r.back)) && ok;
          ok = field_ok("status", 32'(exp_r.status), 32'(got_r.status)) && ok;
          if (!ok) fail_cnt++;
        end
        rx_wait = draw_gap();
      end
      if (s_axis_tvalid && s_axis_tready)
        predicted_replies_q.push_back(
            apply_page_op(s_axis_tdata[rpfa_pkg::MODE_W-1:0],
                          s_axis_tdata[rpfa_pkg::MODE_W +: rpfa_pkg::PAGE_W]));
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a long stretch without any handshake means the block hung.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      wdog_cnt <= 0;
    end else if (wdog_cnt >= WDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      wdog_cnt <= wdog_cnt + 1;
    end
  end

  task automatic queue_op(input logic [rpfa_pkg::MODE_W-1:0] mode,
                          input logic [rpfa_pkg::PAGE_W-1:0] page,
                          input logic hold = 1'b0);
    page_req_t r;
    r.hold = hold;
    r.mode = mode;
    r.page = page;
    req_q.push_back(r);
  endtask

  // Returns at a falling edge once every request is sent and every reply is back.
  task automatic wait_idle();
    @(negedge clk_i);
    while (req_q.size() != 0 || s_axis_tvalid || sent_total != done_total)
      @(negedge clk_i);
  endtask

  task automatic write_first_page(input logic [rpfa_pkg::PAGE_W-1:0] value);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    gen_first = value;
  endtask

  function automatic logic [rpfa_pkg::PAGE_W-1:0] pick_page();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 70) return TOP_WINDOW_LO + rpfa_pkg::PAGE_W'($urandom_range(0, 63));
    if (k < 78) return gen_first;
    if (k < 85) return gen_first - 1'b1;
    return rpfa_pkg::PAGE_W'($urandom_range(0, NPAGES - 1));
  endfunction

  function automatic logic [rpfa_pkg::MODE_W-1:0] pick_mode();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 25) return rpfa_pkg::MODE_ALLOC;
    if (k < 50) return rpfa_pkg::MODE_FREE;
    if (k < 68) return rpfa_pkg::MODE_INC;
    if (k < 78) return rpfa_pkg::MODE_DEC;
    if (k < 93) return rpfa_pkg::MODE_READ;
    case ($urandom_range(0, 2))
      0:       return MODE_RSVD5;
      1:       return MODE_RSVD6;
      default: return MODE_RSVD7;
    endcase
  endfunction

  // Sends random requests in chunks, each chunk with or without random waits.
  task automatic random_phase(input logic [rpfa_pkg::PAGE_W-1:0] first,
                              input int unsigned chunks);
    write_first_page(first);
    repeat (chunks) begin
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (50) queue_op(pick_mode(), pick_page(), $urandom_range(0, 49) == 0);
      wait_idle();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The first allocation must hand out the highest frame.
    write_first_page('0);
    queue_op(rpfa_pkg::MODE_ALLOC, '0);
    queue_op(rpfa_pkg::MODE_READ, 15'h7FFF);
    queue_op(rpfa_pkg::MODE_INC, 15'h7FFF);
    queue_op(rpfa_pkg::MODE_DEC, 15'h7FFF);
    queue_op(rpfa_pkg::MODE_FREE, 15'h7FFF);  // count reaches zero, frame goes back
    queue_op(rpfa_pkg::MODE_FREE, 15'h7FFF);  // free at count zero underflows
    queue_op(rpfa_pkg::MODE_DEC, 15'h7FFF);   // so does a decrement
    queue_op(rpfa_pkg::MODE_ALLOC, '0);       // comes from the explicit stack
    queue_op(rpfa_pkg::MODE_ALLOC, '0);       // comes from the fresh region
    queue_op(rpfa_pkg::MODE_READ, '0);
    queue_op(MODE_RSVD5, 15'h7FFE);
    queue_op(MODE_RSVD6, 15'h7FFE);
    queue_op(MODE_RSVD7, 15'h5555);
    queue_op(rpfa_pkg::MODE_INC, '0);         // raise the count of a free frame
    queue_op(rpfa_pkg::MODE_FREE, '0, 1'b1);  // and push it while it is still fresh
    queue_op(rpfa_pkg::MODE_ALLOC, '0);
    queue_op(rpfa_pkg::MODE_FREE, '0);
    queue_op(rpfa_pkg::MODE_READ, 15'h2AAA);

    // Highest first page: one stacked frame is left, then the pool is empty.
    write_first_page(15'h7FFF);
    queue_op(rpfa_pkg::MODE_ALLOC, '0);
    queue_op(rpfa_pkg::MODE_ALLOC, '0);
    queue_op(rpfa_pkg::MODE_FREE, 15'h4000);
    queue_op(rpfa_pkg::MODE_INC, 15'h7FFF);
    queue_op(rpfa_pkg::MODE_READ, 15'h7FFF);
    queue_op(rpfa_pkg::MODE_READ, 15'h7FFE);

    // Count saturation at the top.
    write_first_page('0);
    idle_on = 1'b0;
    repeat (CNT_MAX + 1) queue_op(rpfa_pkg::MODE_INC, OVF_PAGE);
    queue_op(rpfa_pkg::MODE_DEC, OVF_PAGE);
    queue_op(rpfa_pkg::MODE_READ, OVF_PAGE);
    wait_idle();
    idle_on = 1'b1;

    // Random part under several settings; a small pool runs out often.
    random_phase('0, 6);
    random_phase(15'd32720, 6);
    random_phase(rpfa_pkg::PAGE_W'($urandom_range(0, NPAGES - 1)), 6);

    repeat (16) @(posedge clk_i);
    @(negedge clk_i);
    if (predicted_replies_q.size() != 0) begin
      $error("%0d predicted replies never returned", predicted_replies_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: refcounted_page_frame_allocator.f
rtl/core/rpfa_pkg.sv
rtl/core/rpfa_ram.sv
rtl/core/rpfa_ctrl.sv
rtl/core/rpfa_dp.sv
rtl/core/refcounted_page_frame_allocator.sv
sim/refcounted_page_frame_allocator_tb.sv
